// ----- sv/deq_pkg.sv -----
// Shared types, widths and command codes for the double-ended queue with search.
`default_nettype none
package deq_pkg;

    // Storage size and derived widths.
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int CMD_W   = 3;
    localparam int STAT_W  = 2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_count;
    typedef logic [IDX_W-1:0]         t_index;
    typedef logic [CMD_W-1:0]         t_cmd;
    typedef logic [STAT_W-1:0]        t_status;

    // Command codes.
    localparam t_cmd CMD_PUSH_FRONT = 3'd0;
    localparam t_cmd CMD_PUSH_BACK  = 3'd1;
    localparam t_cmd CMD_POP_FRONT  = 3'd2;
    localparam t_cmd CMD_POP_BACK   = 3'd3;
    localparam t_cmd CMD_SEARCH     = 3'd4;
    localparam t_cmd CMD_REVERSE    = 3'd5;

    // Status codes.
    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    // Control broadcast from the sequencer to every cell in the chain.
    typedef struct packed {
        logic   shift_up;    // push at the low end: every cell takes its lower neighbor
        logic   shift_down;  // pop at the low end: every cell takes its upper neighbor
        logic   write_top;   // push at the high end: the cell at the count position loads
        t_count count;       // current number of held elements
        t_word  value;       // value to push or search target
    } t_cell_ctrl;

endpackage
`default_nettype wire

// ----- sv/deq_if.sv -----
// Valid/ready channel interfaces for commands and results of the queue.
`default_nettype none
interface deq_cmd_if;
    import deq_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_word value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface deq_res_if;
    import deq_pkg::*;

    logic    valid;
    logic    ready;
    t_word   popped_value;
    logic    found;
    t_status status;
    t_count  occupancy;

    modport source (output valid, output popped_value, output found, output status,
                    output occupancy, input ready);
    modport sink   (input valid, input popped_value, input found, input status,
                    input occupancy, output ready);
endinterface
`default_nettype wire

// ----- sv/deq_cell.sv -----
// One storage cell of the queue chain: holds one element and compares it.
`default_nettype none
module deq_cell (
    input  wire logic                i_clk,
    input  wire deq_pkg::t_cell_ctrl i_ctrl,
    input  wire deq_pkg::t_index     i_idx,
    input  wire deq_pkg::t_word      i_from_lo,
    input  wire deq_pkg::t_word      i_from_hi,
    output      deq_pkg::t_word      o_data,
    output      logic                o_match,
    output      deq_pkg::t_word      o_top_data
);
    import deq_pkg::*;

    t_word  r_data;
    t_word  n_data;
    t_count w_pos;
    logic   w_valid;
    logic   w_is_top;

    assign w_pos    = t_count'(i_idx);
    assign w_valid  = w_pos < i_ctrl.count;
    assign w_is_top = w_valid && (w_pos + t_count'(1) == i_ctrl.count);

    // Next content: shift from a neighbor or load the pushed value.
    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_up) begin
            n_data = i_from_lo;
        end else if (i_ctrl.shift_down) begin
            n_data = i_from_hi;
        end else if (i_ctrl.write_top && (w_pos == i_ctrl.count)) begin
            n_data = i_ctrl.value;
        end
    end

    // Element storage needs no reset; occupancy decides what is valid.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    // Local compare against the target and gated read of the high-end element.
    assign o_data     = r_data;
    assign o_match    = w_valid && (r_data == i_ctrl.value);
    assign o_top_data = w_is_top ? r_data : '0;

endmodule
`default_nettype wire

// ----- sv/double_ended_queue_with_search_unit.sv -----
// Top level: sequencer, chain of storage cells and registered result stage.
// A result is valid in the cycle after its command transaction is accepted.
// Throughput: one command per cycle whenever the result register is empty or being taken;
// every command, search included, completes as it is accepted, because each cell compares its
// own element and the match bits are OR-combined along the chain.
// Reset clears the element count, the direction flag and the result valid, but not the cells.
`default_nettype none
module double_ended_queue_with_search_unit (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    deq_cmd_if.sink   i_cmd,
    deq_res_if.source o_res
);
    import deq_pkg::*;

    // State of the queue.
    t_count  r_count;
    t_count  n_count;
    logic    r_rev;
    logic    n_rev;

    // Result register.
    logic    r_out_valid;
    t_word   r_popped;
    t_word   n_popped;
    logic    r_found;
    logic    n_found;
    t_status r_status;
    t_status n_status;

    t_cell_ctrl w_ctrl;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;
    logic       w_low;

    t_word      c_data [DEPTH];
    t_word      c_top  [DEPTH];
    logic [DEPTH-1:0] c_match;
    t_word      w_top_data;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == t_count'(DEPTH));
    assign w_empty     = (r_count == '0);

    // High-end element: only the top valid cell drives its word; all other cells drive zero.
    always_comb begin
        w_top_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_top_data = w_top_data | c_top[k];
        end
    end

    // Command decoder: cell controls, next state and the result fields.
    always_comb begin
        w_ctrl            = '0;
        w_ctrl.count      = r_count;
        w_ctrl.value      = i_cmd.value;
        n_count           = r_count;
        n_rev             = r_rev;
        n_popped          = '0;
        n_found           = 1'b0;
        n_status          = STAT_OK;
        w_low             = 1'b0;
        if (w_accept) begin
            unique case (i_cmd.cmd) inside
                CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                    w_low = (i_cmd.cmd == CMD_PUSH_FRONT) != r_rev;
                    if (w_full) begin
                        n_status = STAT_FULL;
                    end else begin
                        w_ctrl.shift_up  = w_low;
                        w_ctrl.write_top = !w_low;
                        n_count          = r_count + t_count'(1);
                    end
                end
                CMD_POP_FRONT, CMD_POP_BACK: begin
                    w_low = (i_cmd.cmd == CMD_POP_FRONT) != r_rev;
                    if (w_empty) begin
                        n_status = STAT_EMPTY;
                    end else begin
                        w_ctrl.shift_down = w_low;
                        n_popped          = w_low ? c_data[0] : w_top_data;
                        n_count           = r_count - t_count'(1);
                    end
                end
                CMD_SEARCH: begin
                    n_found = |c_match;
                end
                CMD_REVERSE: begin
                    n_rev = !r_rev;
                end
                default: begin
                end
            endcase
        end
    end

    // Chain of cells; each end is fed by the pushed value or zero.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_lo;
        t_word w_hi;
        if (g == 0) begin : g_first
            assign w_lo = i_cmd.value;
        end else begin : g_mid_lo
            assign w_lo = c_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_hi = '0;
        end else begin : g_mid_hi
            assign w_hi = c_data[g+1];
        end
        deq_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (w_ctrl),
            .i_idx      (t_index'(g)),
            .i_from_lo  (w_lo),
            .i_from_hi  (w_hi),
            .o_data     (c_data[g]),
            .o_match    (c_match[g]),
            .o_top_data (c_top[g])
        );
    end

    // Control state with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_rev   <= n_rev;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload is captured with each accepted transaction.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_popped <= n_popped;
            r_found  <= n_found;
            r_status <= n_status;
        end
    end

    // The occupancy reported is the count after the step, held with the result.
    t_count r_occ;
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_occ <= n_count;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.popped_value = r_popped;
    assign o_res.found        = r_found;
    assign o_res.status       = r_status;
    assign o_res.occupancy    = r_occ;

endmodule
`default_nettype wire
